>>> hdl/tac_pkg.sv
// tac_pkg: shared types, constants and helpers of the touch averaging block
// no dependencies; imported by every module of the block
`default_nettype none

package tac_pkg;

    // field and datapath widths
    localparam int BYTE_W    = 8;
    localparam int RAW_W     = 12;
    localparam int SUM_W     = 20;
    localparam int COUNT_W   = 8;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 4;
    localparam int SCALE_W   = 12;
    localparam int AX_W      = CFG_W + 1;
    localparam int MAG_W     = CFG_W;
    localparam int PROD_W    = SCALE_W + MAG_W;
    localparam int DVD_W     = PROD_W;
    localparam int DVS_W     = CFG_W;
    localparam int QS_W      = DVD_W + 1;
    localparam int WIDE_W    = DVD_W + 2;
    localparam int COORD_W   = 16;

    // default block configuration
    localparam int DEF_SAMPLE_COUNT  = 8;
    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;

    // calibration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_SPAN   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN   = 4'd3;

    // calibration reset values
    localparam logic signed [CFG_W-1:0] RST_OFFSET = 14'sd0;
    localparam logic signed [CFG_W-1:0] RST_SPAN   = 14'sd4096;

    // one controller conversion
    typedef struct packed {
        logic [BYTE_W-1:0] x_high_byte;
        logic [BYTE_W-1:0] x_low_byte;
        logic [BYTE_W-1:0] y_high_byte;
        logic [BYTE_W-1:0] y_low_byte;
    } sample_t;

    // one calibrated coordinate pair
    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      span_error;
    } result_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_FIN
    } tac_state_t;

    // which division the shared divider is running
    typedef enum logic [1:0] {
        PH_AVG_X,
        PH_AVG_Y,
        PH_SCALE_X,
        PH_SCALE_Y
    } tac_phase_t;

    // clamp a wide signed value into the 16-bit coordinate range
    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32767);
        lo = -WIDE_W'(32768);
        if (v > hi)
            sat16 = 16'sh7FFF;
        else if (v < lo)
            sat16 = 16'sh8000;
        else
            sat16 = v[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/tac_accum.sv
// tac_accum: raw 12-bit rebuild of each conversion, running sums and sample count
// depends on tac_pkg
`default_nettype none

module tac_accum
    import tac_pkg::*;
#(
    parameter int SAMPLE_COUNT = DEF_SAMPLE_COUNT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             add,
    input  wire sample_t          sample,
    input  wire logic             clear,
    output logic [SUM_W-1:0]      sum_x,
    output logic [SUM_W-1:0]      sum_y,
    output logic                  last
);

    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_x_next;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [SUM_W-1:0]   sum_y_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [RAW_W-1:0]   raw_x;
    logic [RAW_W-1:0]   raw_y;
    logic [COUNT_W:0]   count_inc;

    // rebuild raw values, top bit of the high byte dropped
    assign raw_x = {sample.x_high_byte[6:0], sample.x_low_byte[7:3]};
    assign raw_y = {sample.y_high_byte[6:0], sample.y_low_byte[7:3]};

    // this word completes the averaging window
    assign count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign last      = (count_inc == (COUNT_W+1)'(SAMPLE_COUNT));

    // sums wrap at their width
    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        count_next = count_reg;
        if (clear)
        begin
            sum_x_next = '0;
            sum_y_next = '0;
            count_next = '0;
        end
        else if (add)
        begin
            sum_x_next = sum_x_reg + SUM_W'(raw_x);
            sum_y_next = sum_y_reg + SUM_W'(raw_y);
            count_next = count_inc[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            count_reg <= count_next;
        end
    end

    assign sum_x = sum_x_reg;
    assign sum_y = sum_y_reg;

endmodule

`default_nettype wire

>>> hdl/tac_div.sv
// tac_div: shared restoring divider, one quotient bit per cycle, unsigned operands
// depends on tac_pkg; divisor must be nonzero
`default_nettype none

module tac_div
    import tac_pkg::*;
#(
    parameter int NUM_W = DVD_W,
    parameter int DEN_W = DVS_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0]      quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             fits;

    // one trial subtraction
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = !trial[DEN_W+1];

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> hdl/touch_average_calibrate.sv
// touch_average_calibrate: top level, calibration registers, sequencer and result register
// depends on tac_pkg, tac_accum, tac_div
//
//   channel  | direction | handshake                | word
//   sample   | in        | sample_valid / stall     | sample_t, four conversion bytes
//   result   | out       | result_valid / stall     | result_t, screen_x, screen_y, span_error
//   cfg      | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data (14-bit signed)
//
// a sample that does not close the window is only added to the running sums
// the closing sample starts two averaging divisions on one shared divider of 26 quotient
// bits, then, unless a span is zero, a multiply step and a scaling division per axis
// sample_stall is high while the sequencer runs; a result waiting on result_stall
// only holds the sequencer at its final step, earlier samples are still taken
// reset clears the sums, the count and the calibration to offset 0, span 4096
`default_nettype none

module touch_average_calibrate
    import tac_pkg::*;
#(
    parameter int SAMPLE_COUNT  = DEF_SAMPLE_COUNT,
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire sample_t               sample,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    // calibration registers
    logic signed [CFG_W-1:0] x_offset_reg;
    logic signed [CFG_W-1:0] x_span_reg;
    logic signed [CFG_W-1:0] y_offset_reg;
    logic signed [CFG_W-1:0] y_span_reg;

    // sequencer and datapath
    tac_state_t                state_reg;
    tac_state_t                state_next;
    tac_phase_t                phase_reg;
    tac_phase_t                phase_next;
    logic signed [AX_W-1:0]    ax_reg;
    logic signed [AX_W-1:0]    ax_next;
    logic signed [AX_W-1:0]    ay_reg;
    logic signed [AX_W-1:0]    ay_next;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    logic                      neg_reg;
    logic                      neg_next;
    logic                      err_reg;
    logic                      err_next;
    logic signed [COORD_W-1:0] sx_reg;
    logic signed [COORD_W-1:0] sx_next;
    logic signed [COORD_W-1:0] sy_reg;
    logic signed [COORD_W-1:0] sy_next;
    result_t                   result_reg;
    result_t                   result_next;
    logic                      result_valid_reg;
    logic                      result_valid_next;

    logic                      sample_take;
    logic                      acc_clear;
    logic [SUM_W-1:0]          sum_x;
    logic [SUM_W-1:0]          sum_y;
    logic                      last;
    logic                      div_start;
    logic [DVD_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic [DVD_W-1:0]          div_quo;
    logic                      div_done;

    logic signed [AX_W-1:0]    cur_a;
    logic signed [AX_W-1:0]    cur_a_neg;
    logic [MAG_W-1:0]          a_mag;
    logic signed [CFG_W-1:0]   cur_span;
    logic signed [CFG_W-1:0]   cur_span_neg;
    logic [MAG_W-1:0]          span_mag;
    logic [SCALE_W-1:0]        cur_scale;
    logic [RAW_W-1:0]          avg;
    logic signed [AX_W-1:0]    avg_s;
    logic signed [QS_W-1:0]    quo_signed;
    logic signed [WIDE_W-1:0]  sx_wide;
    logic signed [WIDE_W-1:0]  sy_wide;
    logic                      span_zero;

    // configuration writes, indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg <= RST_OFFSET;
            x_span_reg   <= RST_SPAN;
            y_offset_reg <= RST_OFFSET;
            y_span_reg   <= RST_SPAN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_X_OFFSET: x_offset_reg <= cfg_data;
                REG_X_SPAN:   x_span_reg   <= cfg_data;
                REG_Y_OFFSET: y_offset_reg <= cfg_data;
                REG_Y_SPAN:   y_span_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // input side
    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_take  = sample_valid && !sample_stall;

    tac_accum #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .add    (sample_take),
        .sample (sample),
        .clear  (acc_clear),
        .sum_x  (sum_x),
        .sum_y  (sum_y),
        .last   (last)
    );

    // operand selection for the multiply and divide steps
    assign cur_a        = (phase_reg == PH_SCALE_X) ? ax_reg : ay_reg;
    assign cur_a_neg    = -cur_a;
    assign a_mag        = cur_a[AX_W-1] ? cur_a_neg[MAG_W-1:0] : cur_a[MAG_W-1:0];
    assign cur_span     = (phase_reg == PH_SCALE_X) ? x_span_reg : y_span_reg;
    assign cur_span_neg = -cur_span;
    assign span_mag     = cur_span[CFG_W-1] ? cur_span_neg : cur_span;
    assign cur_scale    = (phase_reg == PH_SCALE_X) ? SCALE_W'(SCREEN_WIDTH)
                                                    : SCALE_W'(SCREEN_HEIGHT);

    always_comb
    begin
        case (phase_reg)
            PH_AVG_X:
            begin
                div_dividend = DVD_W'(sum_x);
                div_divisor  = DVS_W'(SAMPLE_COUNT);
            end
            PH_AVG_Y:
            begin
                div_dividend = DVD_W'(sum_y);
                div_divisor  = DVS_W'(SAMPLE_COUNT);
            end
            default:
            begin
                div_dividend = prod_reg;
                div_divisor  = span_mag;
            end
        endcase
    end

    tac_div #(
        .NUM_W (DVD_W),
        .DEN_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    // quotient post-processing: average, signed scaled coordinate
    assign avg        = div_quo[RAW_W-1:0];
    assign avg_s      = signed'(AX_W'(avg));
    assign quo_signed = neg_reg ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
    assign sy_wide    = WIDE_W'(quo_signed);
    assign sx_wide    = signed'(WIDE_W'(SCREEN_WIDTH)) - sy_wide;
    assign span_zero  = (x_span_reg == '0) || (y_span_reg == '0);

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_AVG_X;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        err_reg    <= err_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        result_reg <= result_next;
    end

    // next state and step control
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        ax_next           = ax_reg;
        ay_next           = ay_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        err_next          = err_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        div_start         = 1'b0;
        acc_clear         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_take && last)
                begin
                    phase_next = PH_AVG_X;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (phase_reg)
                        PH_AVG_X:
                        begin
                            ax_next    = avg_s - AX_W'(x_offset_reg);
                            phase_next = PH_AVG_Y;
                            state_next = ST_DIV_GO;
                        end
                        PH_AVG_Y:
                        begin
                            ay_next   = avg_s - AX_W'(y_offset_reg);
                            acc_clear = 1'b1;
                            err_next  = span_zero;
                            if (span_zero)
                                state_next = ST_FIN;
                            else
                            begin
                                phase_next = PH_SCALE_X;
                                state_next = ST_MUL;
                            end
                        end
                        PH_SCALE_X:
                        begin
                            sx_next    = sat16(sx_wide);
                            phase_next = PH_SCALE_Y;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            sy_next    = sat16(sy_wide);
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(cur_scale) * PROD_W'(a_mag);
                neg_next   = cur_a[AX_W-1] ^ cur_span[CFG_W-1];
                state_next = ST_DIV_GO;
            end
            ST_FIN:
            begin
                // load once the output register is free
                if (!result_valid_reg || !result_stall)
                begin
                    if (err_reg)
                    begin
                        result_next.screen_x   = '0;
                        result_next.screen_y   = '0;
                        result_next.span_error = 1'b1;
                    end
                    else
                    begin
                        result_next.screen_x   = sx_reg;
                        result_next.screen_y   = sy_reg;
                        result_next.span_error = 1'b0;
                    end
                    result_valid_next = 1'b1;
                    phase_next        = PH_AVG_X;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
